>>> rtl/mavg_pkg.sv
// Package with the shared constants and helper function of the moving average window.
`timescale 1ns / 1ps

package mavg_pkg;

   // Default sample width and deepest window the ring can hold.
   localparam int unsigned SAMPLE_BITS_DEFAULT = 16;
   localparam int unsigned WINDOW_MAX_DEFAULT  = 64;

   // Width of the window size register and of the fill count.
   localparam int unsigned CNT_BITS = 7;

   // Window size after reset.
   localparam logic [CNT_BITS-1:0] WINDOW_SIZE_RESET = CNT_BITS'(8);

   // Address width for a store of the given depth, never below one bit.
   function automatic int unsigned addr_bits(input int unsigned depth);
      int unsigned bits;
      bits = (depth > 1) ? $clog2(depth) : 1;
      return bits;
   endfunction

endpackage

>>> rtl/mavg_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mavg_ram #(
   parameter int unsigned WIDTH = mavg_pkg::SAMPLE_BITS_DEFAULT,
   parameter int unsigned DEPTH = mavg_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [mavg_pkg::addr_bits(DEPTH)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [mavg_pkg::addr_bits(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mavg_divider.sv
// Iterative restoring divider: signed running sum by unsigned fill count, one bit per cycle.
`timescale 1ns / 1ps

module mavg_divider #(
   parameter int unsigned SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  logic signed [SAMPLE_BITS+mavg_pkg::CNT_BITS-1:0]  dividend,
   input  logic [mavg_pkg::CNT_BITS-1:0]                     divisor,
   output logic                                              done,
   output logic signed [SAMPLE_BITS-1:0]                     quotient
);

   localparam int unsigned CNT_BITS  = mavg_pkg::CNT_BITS;
   localparam int unsigned SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int unsigned STEP_BITS = $clog2(SUM_BITS + 1);

   logic [SUM_BITS-1:0]  quo_ff,  quo_in;
   logic [CNT_BITS-1:0]  rem_ff,  rem_in;
   logic [CNT_BITS-1:0]  dvs_ff,  dvs_in;
   logic                 neg_ff,  neg_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [SAMPLE_BITS-1:0] result_ff, result_in;

   logic [SUM_BITS-1:0]   magnitude;
   logic [CNT_BITS+1:0]   trial;
   logic [SUM_BITS-1:0]   quo_next;
   logic [SUM_BITS-1:0]   quo_signed;

   // Magnitude of the dividend; the most negative sum still fits unsigned.
   assign magnitude = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);

   // One trial subtraction of the shifted remainder against the divisor.
   assign trial    = {1'b0, rem_ff, quo_ff[SUM_BITS-1]} - {2'b00, dvs_ff};
   assign quo_next = {quo_ff[SUM_BITS-2:0], ~trial[CNT_BITS+1]};

   // Restore the sign of the finished quotient.
   assign quo_signed = neg_ff ? (~quo_next + SUM_BITS'(1)) : quo_next;

   // Sequencing of the bit steps.
   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         quo_in  = magnitude;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_BITS-1];
         step_in = STEP_BITS'(SUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = quo_next;
         rem_in  = trial[CNT_BITS+1] ? {rem_ff[CNT_BITS-2:0], quo_ff[SUM_BITS-1]}
                                     : trial[CNT_BITS-1:0];
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = quo_signed[SAMPLE_BITS-1:0];
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

>>> rtl/moving_average_window.sv
// Top level of the moving average window: sequencer, running sum, ring store and divider.
`timescale 1ns / 1ps

// Averages the most recent window_size signed samples held in a ring store. One word is
// taken at a time: req_stall stays high from acceptance until the result is loaded into the
// output register. Once the window is full, the ring store's registered read fetches the
// oldest word, which is subtracted from the running sum before the new one is added; while
// the window is filling only the add is done. The restoring divider then produces one
// quotient bit per cycle over the SAMPLE_BITS + 7 bit running sum before the output load; a
// window size of zero skips the ring store and the divider. A finished result waits in the
// output register while the next word is being worked on; if it is still there when the next
// result is ready, the block holds until it is taken. Writing the window size clears the sum,
// count and write position but keeps the ring contents; a window size of zero returns
// average 0 and filled 0, and sizes above WINDOW_MAX act as WINDOW_MAX.
module moving_average_window #(
   parameter int unsigned WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEFAULT,
   parameter int unsigned SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_average,
   output logic [mavg_pkg::CNT_BITS-1:0]        rsp_filled,
   input  logic                                 csr_wr_en,
   input  logic [mavg_pkg::CNT_BITS-1:0]        csr_wr_data
);

   localparam int unsigned CNT_BITS  = mavg_pkg::CNT_BITS;
   localparam int unsigned SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int unsigned AW        = mavg_pkg::addr_bits(WINDOW_MAX);
   localparam int unsigned CMP_BITS  = AW + CNT_BITS;
   localparam int unsigned SIZE_CLIP = (WINDOW_MAX > ((1 << CNT_BITS) - 1)) ?
                                       ((1 << CNT_BITS) - 1) : WINDOW_MAX;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_READ      = 7'b0000010,
      ST_SUB       = 7'b0000100,
      ST_ADD       = 7'b0001000,
      ST_DIV_START = 7'b0010000,
      ST_DIV_WAIT  = 7'b0100000,
      ST_OUT       = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_BITS-1:0]           window_size_ff, window_size_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [CNT_BITS-1:0]           fill_ff, fill_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [AW-1:0]                 slot_ff, slot_in;
   logic                          grow_ff, grow_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_average_ff, rsp_average_in;
   logic [CNT_BITS-1:0]           rsp_filled_ff, rsp_filled_in;

   logic [CNT_BITS-1:0]           size_eff;
   logic [AW-1:0]                 slot_use;
   logic [AW:0]                   slot_inc;
   logic signed [SUM_BITS-1:0]    addend;
   logic signed [SUM_BITS-1:0]    sum_result;
   logic [SAMPLE_BITS-1:0]        ram_rd_data;
   logic                          ram_wr_en;
   logic                          div_start;
   logic                          div_done;
   logic signed [SAMPLE_BITS-1:0] div_quotient;

   // Effective window size, saturated at the ring depth.
   assign size_eff = (window_size_ff > CNT_BITS'(SIZE_CLIP)) ? CNT_BITS'(SIZE_CLIP)
                                                             : window_size_ff;

   // Slot for this word; a position beyond a shrunk window restarts at zero.
   assign slot_use = (CMP_BITS'(pos_ff) >= CMP_BITS'(size_eff)) ? '0 : pos_ff;
   assign slot_inc = {1'b0, slot_ff} + (AW + 1)'(1);

   // Shared adder of the running sum: subtracts the oldest word once the window is full, then adds the new one.
   assign addend     = (state_ff == ST_SUB) ? -SUM_BITS'($signed(ram_rd_data))
                                            : SUM_BITS'(sample_ff);
   assign sum_result = sum_ff + addend;

   assign ram_wr_en = (state_ff == ST_ADD);
   assign div_start = (state_ff == ST_DIV_START) && (fill_ff != '0);

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      window_size_in = window_size_ff;
      sum_in         = sum_ff;
      pos_in         = pos_ff;
      fill_in        = fill_ff;
      sample_in      = sample_ff;
      slot_in        = slot_ff;
      grow_in        = grow_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      rsp_filled_in  = rsp_filled_ff;

      // The output register empties when its word is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               slot_in   = slot_use;
               grow_in   = (fill_ff < size_eff);
               if (size_eff == '0) begin
                  state_in = ST_DIV_START;
               end else if (fill_ff < size_eff) begin
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SUB;
         end
         ST_SUB: begin
            sum_in   = sum_result;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in  = sum_result;
            fill_in = fill_ff + CNT_BITS'(grow_ff);
            pos_in  = (CMP_BITS'(slot_inc) >= CMP_BITS'(size_eff)) ? '0 : slot_inc[AW-1:0];
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            if (fill_ff == '0) begin
               avg_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               avg_in   = div_quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = avg_ff;
               rsp_filled_in  = fill_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A window size write restarts the window.
      if (csr_wr_en) begin
         window_size_in = csr_wr_data;
         sum_in         = '0;
         pos_in         = '0;
         fill_in        = '0;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= mavg_pkg::WINDOW_SIZE_RESET;
         sum_ff         <= '0;
         pos_ff         <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         sum_ff         <= sum_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      slot_ff        <= slot_in;
      grow_ff        <= grow_in;
      avg_ff         <= avg_in;
      rsp_average_ff <= rsp_average_in;
      rsp_filled_ff  <= rsp_filled_in;
   end

   // Ring store of the recent samples.
   mavg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // Sum divided by the fill count.
   mavg_divider #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_filled  = rsp_filled_ff;

   // The fill count never exceeds the effective window.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= size_eff)
      else $error("fill count exceeds the window size");

   // An accepted word always starts the sequence.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside its wait state");

   // A delivered fill count is within the largest effective window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_filled_ff <= CNT_BITS'(SIZE_CLIP)))
      else $error("result fill count beyond the ring depth");

endmodule
